// File: rtl/core/rps_pkg.sv
// Shared types, constants and codes of the region pixel statistics block.
`default_nettype none

package rps_pkg;

    // Table and image geometry
    localparam int REGION_COUNT = 256;
    localparam int IMAGE_SIDE   = 4096;
    localparam int ADDR_W       = $clog2(REGION_COUNT);

    // Command queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // Item actions
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [2:0] REG_DISK_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_DISK_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_DISK_RADIUS     = 3'd2;
    localparam logic [2:0] REG_PIXEL_AREA      = 3'd3;
    localparam logic [2:0] REG_RAW_UNCERT_STEP = 3'd4;
    localparam logic [2:0] REG_LIMB_LIMIT      = 3'd5;
    localparam logic [2:0] REG_RADIUS_REL_VAR  = 3'd6;
    localparam logic [2:0] REG_PIXEL_REL_VAR   = 3'd7;

    // Statistic codes of a read run
    localparam logic [3:0] ST_PIXEL_COUNT = 4'd0;
    localparam logic [3:0] ST_VALID_COUNT = 4'd1;
    localparam logic [3:0] ST_SUM_X       = 4'd2;
    localparam logic [3:0] ST_SUM_Y       = 4'd3;
    localparam logic [3:0] ST_TOTAL       = 4'd4;
    localparam logic [3:0] ST_WSUM_X      = 4'd5;
    localparam logic [3:0] ST_WSUM_Y      = 4'd6;
    localparam logic [3:0] ST_MIN         = 4'd7;
    localparam logic [3:0] ST_MAX         = 4'd8;
    localparam logic [3:0] ST_RAW_AREA    = 4'd9;
    localparam logic [3:0] ST_RAW_UNC     = 4'd10;
    localparam logic [3:0] ST_DISK_AREA   = 4'd11;
    localparam logic [3:0] ST_DISK_UNC    = 4'd12;
    localparam logic [3:0] ST_CLIPPED     = 4'd13;

    // Configuration set
    typedef struct packed {
        logic [19:0] center_x;
        logic [19:0] center_y;
        logic [19:0] radius;
        logic [31:0] pixel_area;
        logic [31:0] raw_step;
        logic [15:0] limb_limit;
        logic [15:0] radius_rel_var;
        logic [15:0] pixel_rel_var;
    } cfg_t;

    // Classified command passed through the queue
    typedef struct packed {
        action_t             kind;
        logic [ADDR_W-1:0]   label;
        logic [11:0]         x;
        logic [11:0]         y;
        logic [31:0]         inten;
        logic                ivalid;
        logic                border;
    } op_t;

    // One region table entry
    typedef struct packed {
        logic [24:0] pixel_count;
        logic [24:0] valid_count;
        logic [36:0] sum_x;
        logic [36:0] sum_y;
        logic [63:0] total;
        logic [63:0] wsum_x;
        logic [63:0] wsum_y;
        logic [31:0] imin;
        logic [31:0] imax;
        logic [63:0] area_sum;
        logic [63:0] raw_unc;
        logic [63:0] disk_area;
        logic [63:0] disk_unc;
        logic        clipped;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/rps_front.sv
// Front end: configuration registers and input item classification.
`default_nettype none

module rps_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           action,
    input  wire logic [7:0]           region_label,
    input  wire logic [11:0]          pixel_x,
    input  wire logic [11:0]          pixel_y,
    input  wire logic [31:0]          intensity,
    input  wire logic                 intensity_valid,
    input  wire logic                 at_border,
    input  wire logic                 q_full,
    output logic                      q_push,
    output rps_pkg::op_t              q_op,
    output rps_pkg::cfg_t             cfg
);

    rps_pkg::cfg_t cfg_reg;
    logic          accept;
    logic          label_ok;
    logic          coord_ok;
    logic          keep;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rps_pkg::REG_DISK_CENTER_X:   cfg_reg.center_x       <= cfg_data[19:0];
                rps_pkg::REG_DISK_CENTER_Y:   cfg_reg.center_y       <= cfg_data[19:0];
                rps_pkg::REG_DISK_RADIUS:     cfg_reg.radius         <= cfg_data[19:0];
                rps_pkg::REG_PIXEL_AREA:      cfg_reg.pixel_area     <= cfg_data;
                rps_pkg::REG_RAW_UNCERT_STEP: cfg_reg.raw_step       <= cfg_data;
                rps_pkg::REG_LIMB_LIMIT:      cfg_reg.limb_limit     <= cfg_data[15:0];
                rps_pkg::REG_RADIUS_REL_VAR:  cfg_reg.radius_rel_var <= cfg_data[15:0];
                rps_pkg::REG_PIXEL_REL_VAR:   cfg_reg.pixel_rel_var  <= cfg_data[15:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Accept while the queue has room; drop items that do nothing
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign label_ok = 32'(region_label) < rps_pkg::REGION_COUNT;
    assign coord_ok = (32'(pixel_x) < rps_pkg::IMAGE_SIDE)
                   && (32'(pixel_y) < rps_pkg::IMAGE_SIDE);

    always_comb
    begin
        unique case (action)
            rps_pkg::ACT_ADD:   keep = label_ok && coord_ok;
            rps_pkg::ACT_READ:  keep = label_ok;
            rps_pkg::ACT_CLEAR: keep = label_ok;
            default:            keep = 1'b0;
        endcase
    end

    assign q_push       = accept && keep;
    assign q_op.kind    = rps_pkg::action_t'(action);
    assign q_op.label   = region_label[rps_pkg::ADDR_W-1:0];
    assign q_op.x       = pixel_x;
    assign q_op.y       = pixel_y;
    assign q_op.inten   = intensity;
    assign q_op.ivalid  = intensity_valid;
    assign q_op.border  = at_border;

endmodule

`default_nettype wire

// File: rtl/core/rps_queue.sv
// Short command queue between the front end and the execution back end.
`default_nettype none

module rps_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rps_pkg::op_t   push_op,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output rps_pkg::op_t        head_op
);

    localparam int CNT_W = rps_pkg::QPTR_W + 1;

    rps_pkg::op_t               slot_reg [rps_pkg::QUEUE_DEPTH];
    logic [rps_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rps_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;

    assign full       = count_reg == CNT_W'(rps_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_op    = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rps_back.sv
// Back end: region table, add sequencer with iterative sqrt and divide, read emitter.
`default_nettype none

module rps_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rps_pkg::cfg_t  cfg,
    input  wire logic           q_valid,
    input  wire rps_pkg::op_t   q_op,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [3:0]          stat_code,
    output logic [63:0]         stat_value,
    output logic                last
);

    localparam logic [63:0] AREA_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SIGN_MIN = {1'b1, 63'd0};
    localparam logic [6:0]  SQRT_STEPS = 7'd20;
    localparam logic [6:0]  FACT_STEPS = 7'd28;
    localparam logic [6:0]  UNC_STEPS  = 7'd63;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_EMIT,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_SQRT, S_DIV,
        S_M8, S_M9, S_M10, S_M11, S_M12,
        S_UPD
    } state_t;

    // Saturating helpers
    function automatic logic [24:0] inc_cnt(input logic [24:0] a);
        return (&a) ? a : a + 25'd1;
    endfunction

    function automatic logic [36:0] add_sum(input logic [36:0] a, input logic [11:0] b);
        logic [37:0] s;
        s = {1'b0, a} + 38'(b);
        return s[37] ? {37{1'b1}} : s[36:0];
    endfunction

    function automatic logic [63:0] add_area(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] c);
        logic [65:0] s;
        s = 66'(a) + 66'(b) + 66'(c);
        return (s > 66'(AREA_MAX)) ? AREA_MAX : s[63:0];
    endfunction

    function automatic logic [63:0] add_s64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? SIGN_MIN : AREA_MAX;
        end
        return s[63:0];
    endfunction

    state_t                    state_reg;
    rps_pkg::op_t              op_reg;
    rps_pkg::entry_t           mem [rps_pkg::REGION_COUNT];
    rps_pkg::entry_t           rd_data_reg;
    logic                      ent_vld_reg;
    logic [rps_pkg::REGION_COUNT-1:0] vld_reg;

    logic [71:0] mul_reg;
    logic [19:0] dx_reg;
    logic [19:0] dy_reg;
    logic [39:0] r2_reg;
    logic [39:0] dx2_reg;
    logic [39:0] dy2_reg;
    logic [39:0] sigma_reg;
    logic        inside_reg;
    logic [63:0] wx_reg;
    logic [63:0] wy_reg;
    logic [39:0] t1_reg;
    logic [42:0] t_reg;
    logic [55:0] corr_reg;
    logic [66:0] plo_reg;
    logic [50:0] phi_reg;
    logic [39:0] sq_n_reg;
    logic [39:0] sq_res_reg;
    logic [39:0] sq_bit_reg;
    logic [6:0]  cnt_reg;
    logic [59:0] div_rem_reg;
    logic [62:0] div_num_reg;
    logic [62:0] div_q_reg;
    logic [59:0] div_d_reg;
    logic        div_unc_reg;
    logic        disk_ok_reg;
    logic [62:0] unc_q_reg;
    logic [3:0]  code_reg;
    logic        out_valid_reg;
    logic [3:0]  out_code_reg;
    logic [63:0] out_value_reg;
    logic        out_last_reg;

    rps_pkg::entry_t ent;
    rps_pkg::entry_t new_ent;
    logic [47:0] mul_a;
    logic [23:0] mul_b;
    logic [71:0] mul_p;
    logic [31:0] inten_mag;
    logic [63:0] wprod;
    logic [63:0] wsigned;
    logic [19:0] px;
    logic [19:0] py;
    logic [40:0] d2;
    logic [40:0] sq_sum;
    logic        sq_ge;
    logic [60:0] rem_sh;
    logic        div_ge;
    logic [60:0] rem_sub;
    logic [42:0] t_new;
    logic [74:0] p_sum;
    logic [35:0] p_top;
    logic        unc_sat;
    logic [63:0] emit_value;
    logic        mem_we;
    logic [63:0] inten_ext;
    logic [63:0] pa32;

    assign ent    = ent_vld_reg ? rd_data_reg : '0;
    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign mem_we = state_reg == S_UPD;

    assign out_valid  = out_valid_reg;
    assign stat_code  = out_code_reg;
    assign stat_value = out_value_reg;
    assign last       = out_last_reg;

    // Distance from the disk center and intensity magnitude
    assign px        = {op_reg.x, 8'd0};
    assign py        = {op_reg.y, 8'd0};
    assign inten_mag = op_reg.inten[31] ? (~op_reg.inten + 32'd1) : op_reg.inten;
    assign wprod     = {20'd0, mul_reg[43:0]};
    assign wsigned   = op_reg.inten[31] ? (~wprod + 64'd1) : wprod;
    assign d2        = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign inten_ext = {{32{op_reg.inten[31]}}, op_reg.inten};
    assign pa32      = {16'd0, cfg.pixel_area, 16'd0};

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FETCH:
            begin
                mul_a = {28'd0, cfg.radius};
                mul_b = {4'd0, cfg.radius};
            end
            S_M1:
            begin
                mul_a = {28'd0, dx_reg};
                mul_b = {4'd0, dx_reg};
            end
            S_M2:
            begin
                mul_a = {28'd0, dy_reg};
                mul_b = {4'd0, dy_reg};
            end
            S_M3:
            begin
                mul_a = {16'd0, inten_mag};
                mul_b = {12'd0, op_reg.x};
            end
            S_M4:
            begin
                mul_a = {16'd0, inten_mag};
                mul_b = {12'd0, op_reg.y};
            end
            S_M5:
            begin
                mul_a = {8'd0, sigma_reg};
                mul_b = {8'd0, cfg.radius_rel_var};
            end
            S_M6:
            begin
                mul_a = {7'd0, {1'b0, r2_reg} + {1'b0, sigma_reg}};
                mul_b = {8'd0, cfg.pixel_rel_var};
            end
            S_M8:
            begin
                mul_a = {16'd0, cfg.pixel_area};
                mul_b = {8'd0, div_q_reg[15:0]};
            end
            S_M9:
            begin
                mul_a = {5'd0, t_reg};
                mul_b = cfg.pixel_area[23:0];
            end
            S_M10:
            begin
                mul_a = {5'd0, t_reg};
                mul_b = {16'd0, cfg.pixel_area[31:24]};
            end
            S_M11:
            begin
                mul_a = {8'd0, sigma_reg};
                mul_b = {4'd0, sq_res_reg[19:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 72'(mul_a) * 72'(mul_b);

    // One step of the square root and of the restoring divider
    assign sq_sum  = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge   = {1'b0, sq_n_reg} >= sq_sum;
    assign rem_sh  = {div_rem_reg, div_num_reg[62]};
    assign div_ge  = rem_sh >= {1'b0, div_d_reg};
    assign rem_sub = div_ge ? (rem_sh - {1'b0, div_d_reg}) : rem_sh;

    // Uncertainty term and wide numerator
    assign t_new   = 43'({{1'b0, dx_reg} + {1'b0, dy_reg}, 8'd0})
                   + 43'({t1_reg, 1'b0}) + 43'(mul_reg[56:16]);
    assign p_sum   = {8'd0, plo_reg} + {phi_reg, 24'd0};
    assign p_top   = p_sum[74:39];
    assign unc_sat = {24'd0, p_top} >= mul_reg[59:0];

    // Read run value select
    always_comb
    begin
        case (code_reg)
            rps_pkg::ST_PIXEL_COUNT: emit_value = 64'(ent.pixel_count);
            rps_pkg::ST_VALID_COUNT: emit_value = 64'(ent.valid_count);
            rps_pkg::ST_SUM_X:       emit_value = 64'(ent.sum_x);
            rps_pkg::ST_SUM_Y:       emit_value = 64'(ent.sum_y);
            rps_pkg::ST_TOTAL:       emit_value = ent.total;
            rps_pkg::ST_WSUM_X:      emit_value = ent.wsum_x;
            rps_pkg::ST_WSUM_Y:      emit_value = ent.wsum_y;
            rps_pkg::ST_MIN:         emit_value = {{32{ent.imin[31]}}, ent.imin};
            rps_pkg::ST_MAX:         emit_value = {{32{ent.imax[31]}}, ent.imax};
            rps_pkg::ST_RAW_AREA:    emit_value = ent.area_sum;
            rps_pkg::ST_RAW_UNC:     emit_value = ent.raw_unc;
            rps_pkg::ST_DISK_AREA:   emit_value = ent.disk_area;
            rps_pkg::ST_DISK_UNC:    emit_value = ent.disk_unc;
            rps_pkg::ST_CLIPPED:     emit_value = 64'(ent.clipped);
            default:                 emit_value = '0;
        endcase
    end

    // Updated entry for an add
    always_comb
    begin
        new_ent             = ent;
        new_ent.pixel_count = inc_cnt(ent.pixel_count);
        new_ent.sum_x       = add_sum(ent.sum_x, op_reg.x);
        new_ent.sum_y       = add_sum(ent.sum_y, op_reg.y);
        new_ent.area_sum    = add_area(ent.area_sum, pa32, 64'd0);
        new_ent.raw_unc     = add_area(ent.raw_unc, {16'd0, cfg.raw_step, 16'd0},
                                       op_reg.border ? pa32 : 64'd0);
        if (op_reg.ivalid)
        begin
            if ((ent.valid_count == '0) || ($signed(op_reg.inten) > $signed(ent.imax)))
            begin
                new_ent.imax = op_reg.inten;
            end
            if ((ent.valid_count == '0) || ($signed(op_reg.inten) < $signed(ent.imin)))
            begin
                new_ent.imin = op_reg.inten;
            end
            new_ent.valid_count = inc_cnt(ent.valid_count);
            new_ent.total       = add_s64(ent.total, inten_ext);
            new_ent.wsum_x      = add_s64(ent.wsum_x, wx_reg);
            new_ent.wsum_y      = add_s64(ent.wsum_y, wy_reg);
        end
        else
        begin
            new_ent.clipped = 1'b1;
        end
        if (disk_ok_reg)
        begin
            new_ent.disk_area = add_area(ent.disk_area, 64'(corr_reg), 64'd0);
            new_ent.disk_unc  = add_area(ent.disk_unc, {1'b0, unc_q_reg},
                                         op_reg.border ? 64'(corr_reg) : 64'd0);
        end
        else
        begin
            new_ent.clipped = 1'b1;
        end
    end

    // Region table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[op_reg.label] <= new_ent;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[q_op.label];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            ent_vld_reg   <= 1'b0;
            op_reg        <= '0;
            mul_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            r2_reg        <= '0;
            dx2_reg       <= '0;
            dy2_reg       <= '0;
            sigma_reg     <= '0;
            inside_reg    <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            t1_reg        <= '0;
            t_reg         <= '0;
            corr_reg      <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            sq_n_reg      <= '0;
            sq_res_reg    <= '0;
            sq_bit_reg    <= '0;
            cnt_reg       <= '0;
            div_rem_reg   <= '0;
            div_num_reg   <= '0;
            div_q_reg     <= '0;
            div_d_reg     <= '0;
            div_unc_reg   <= 1'b0;
            disk_ok_reg   <= 1'b0;
            unc_q_reg     <= '0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_code_reg  <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            mul_reg <= mul_p;

            // Result taken downstream; while emitting, the next one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg      <= q_op;
                        ent_vld_reg <= vld_reg[q_op.label];
                        unique case (q_op.kind)
                            rps_pkg::ACT_ADD:   state_reg <= S_FETCH;
                            rps_pkg::ACT_READ:  state_reg <= S_FETCH;
                            rps_pkg::ACT_CLEAR: vld_reg[q_op.label] <= 1'b0;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_FETCH:
                begin
                    if (op_reg.kind == rps_pkg::ACT_READ)
                    begin
                        code_reg  <= rps_pkg::ST_PIXEL_COUNT;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        dx_reg      <= (px > cfg.center_x) ? (px - cfg.center_x)
                                                           : (cfg.center_x - px);
                        dy_reg      <= (py > cfg.center_y) ? (py - cfg.center_y)
                                                           : (cfg.center_y - py);
                        disk_ok_reg <= 1'b0;
                        state_reg   <= S_M1;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_code_reg  <= code_reg;
                        out_value_reg <= emit_value;
                        out_last_reg  <= code_reg == rps_pkg::ST_CLIPPED;
                        code_reg      <= code_reg + 4'd1;
                        if (code_reg == rps_pkg::ST_CLIPPED)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_M1:
                begin
                    r2_reg    <= mul_reg[39:0];
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    dx2_reg   <= mul_reg[39:0];
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    dy2_reg   <= mul_reg[39:0];
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    wx_reg     <= wsigned;
                    inside_reg <= {1'b0, r2_reg} > d2;
                    sigma_reg  <= r2_reg - d2[39:0];
                    state_reg  <= S_M5;
                end
                S_M5:
                begin
                    wy_reg    <= wsigned;
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    t1_reg    <= mul_reg[55:16];
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    t_reg <= t_new;
                    if (inside_reg)
                    begin
                        sq_n_reg   <= sigma_reg;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 40'd1 << 38;
                        cnt_reg    <= SQRT_STEPS;
                        state_reg  <= S_SQRT;
                    end
                    else
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg != '0)
                    begin
                        if (sq_ge)
                        begin
                            sq_n_reg   <= sq_n_reg - sq_sum[39:0];
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                        cnt_reg    <= cnt_reg - 7'd1;
                    end
                    else
                    begin
                        // factor = (r << 8) / s
                        div_rem_reg <= '0;
                        div_num_reg <= {cfg.radius, 8'd0, 35'd0};
                        div_q_reg   <= '0;
                        div_d_reg   <= {40'd0, sq_res_reg[19:0]};
                        div_unc_reg <= 1'b0;
                        cnt_reg     <= FACT_STEPS;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg != '0)
                    begin
                        div_rem_reg <= rem_sub[59:0];
                        div_num_reg <= {div_num_reg[61:0], 1'b0};
                        div_q_reg   <= {div_q_reg[61:0], div_ge};
                        cnt_reg     <= cnt_reg - 7'd1;
                    end
                    else if (!div_unc_reg)
                    begin
                        // Beyond the limb limit the pixel is clipped
                        if (div_q_reg > 63'(cfg.limb_limit))
                        begin
                            state_reg <= S_UPD;
                        end
                        else
                        begin
                            state_reg <= S_M8;
                        end
                    end
                    else
                    begin
                        unc_q_reg   <= div_q_reg;
                        disk_ok_reg <= 1'b1;
                        state_reg   <= S_UPD;
                    end
                end
                S_M8:
                begin
                    state_reg <= S_M9;
                end
                S_M9:
                begin
                    corr_reg  <= {mul_reg[47:0], 8'd0};
                    state_reg <= S_M10;
                end
                S_M10:
                begin
                    plo_reg   <= mul_reg[66:0];
                    state_reg <= S_M11;
                end
                S_M11:
                begin
                    phi_reg   <= mul_reg[50:0];
                    state_reg <= S_M12;
                end
                S_M12:
                begin
                    // Quotient at or above 2^63 saturates at once
                    if (unc_sat)
                    begin
                        unc_q_reg   <= AREA_MAX[62:0];
                        disk_ok_reg <= 1'b1;
                        state_reg   <= S_UPD;
                    end
                    else
                    begin
                        div_rem_reg <= {24'd0, p_top};
                        div_num_reg <= {p_sum[38:0], 24'd0};
                        div_q_reg   <= '0;
                        div_d_reg   <= mul_reg[59:0];
                        div_unc_reg <= 1'b1;
                        cnt_reg     <= UNC_STEPS;
                        state_reg   <= S_DIV;
                    end
                end
                S_UPD:
                begin
                    vld_reg[op_reg.label] <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/region_pixel_statistics_top.sv
// Top level of the region pixel statistics block.
// The block keeps saturating per-region accumulators for up to 256 labels and
// answers a read with fourteen coded statistics, the last one flagged. Items
// pass a four-deep command queue, so input is taken while the back end works
// or a result waits. An add of a pixel off the disk skips the square root and
// the divider, and one beyond the limb limit skips the uncertainty divide; a
// read is held by any output stall. The add time is set by the one-bit-per-cycle
// square root (20 steps) and the shared restoring divider (28 steps for the
// correction factor, 63 for the uncertainty).
// Every entry reads as zero after reset through per-entry valid bits; there
// is no clearing pass.
`default_nettype none

module region_pixel_statistics_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  region_label,
    input  wire logic [11:0] pixel_x,
    input  wire logic [11:0] pixel_y,
    input  wire logic [31:0] intensity,
    input  wire logic        intensity_valid,
    input  wire logic        at_border,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       stat_code,
    output logic [63:0]      stat_value,
    output logic             last
);

    rps_pkg::cfg_t cfg;
    rps_pkg::op_t  push_op;
    rps_pkg::op_t  head_op;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          head_valid;

    rps_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .region_label    (region_label),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .intensity       (intensity),
        .intensity_valid (intensity_valid),
        .at_border       (at_border),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_op            (push_op),
        .cfg             (cfg)
    );

    rps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    rps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (head_valid),
        .q_op       (head_op),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stat_code  (stat_code),
        .stat_value (stat_value),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: tb/region_pixel_statistics_checker.sv
// Checker for the region pixel statistics block: tracks the region table and compares read runs.
`timescale 1ns / 1ps

module region_pixel_statistics_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  region_label,
    input  wire logic [11:0] pixel_x,
    input  wire logic [11:0] pixel_y,
    input  wire logic [31:0] intensity,
    input  wire logic        intensity_valid,
    input  wire logic        at_border,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  stat_code,
    input  wire logic [63:0] stat_value,
    input  wire logic        last,
    output int               fail_count,
    output int               pending,
    output int               stats_seen
);

    localparam logic [63:0] CNT_LIM  = (64'd1 << 25) - 64'd1;
    localparam logic [63:0] SUM_LIM  = (64'd1 << 37) - 64'd1;
    localparam logic [63:0] AREA_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [3:0]  code;
        logic [63:0] value;
        logic        last;
    } stat_rec_t;

    rps_pkg::cfg_t   cfg;
    rps_pkg::entry_t region_tbl [rps_pkg::REGION_COUNT];
    stat_rec_t       expected_stats [$];

    assign pending = expected_stats.size();

    // Unsigned add clamped at lim
    function automatic logic [63:0] add_clamp_u(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] lim);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[63:0];
    endfunction

    // Signed 64-bit add clamped at both ends
    function automatic logic [63:0] add_clamp_s(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Accumulate one pixel into entry k
    task automatic accumulate_pixel(int k, logic [11:0] x, logic [11:0] y,
                                    logic [31:0] inten, logic ivalid, logic border);
        rps_pkg::entry_t e;
        logic [63:0]  dx, dy, r2, d2, pa32, sigma, s, factor, corr, t, dvs;
        logic [63:0]  px, py, xs, ys, is, q;
        logic [127:0] num, q128;
        e    = region_tbl[k];
        px   = {52'd0, x} << 8;
        py   = {52'd0, y} << 8;
        dx   = (px > cfg.center_x) ? px - cfg.center_x : cfg.center_x - px;
        dy   = (py > cfg.center_y) ? py - cfg.center_y : cfg.center_y - py;
        r2   = {44'd0, cfg.radius} * {44'd0, cfg.radius};
        d2   = dx * dx + dy * dy;
        pa32 = {32'd0, cfg.pixel_area} << 16;
        xs   = {52'd0, x};
        ys   = {52'd0, y};
        is   = {{32{inten[31]}}, inten};

        // intensity statistics
        if (ivalid)
        begin
            if (e.valid_count == 0 || $signed(inten) > $signed(e.imax))
                e.imax = inten;
            if (e.valid_count == 0 || $signed(inten) < $signed(e.imin))
                e.imin = inten;
            e.valid_count = 25'(add_clamp_u({39'd0, e.valid_count}, 64'd1, CNT_LIM));
            e.total  = add_clamp_s(e.total, is);
            e.wsum_x = add_clamp_s(e.wsum_x, $signed(xs) * $signed(is));
            e.wsum_y = add_clamp_s(e.wsum_y, $signed(ys) * $signed(is));
        end
        else
            e.clipped = 1'b1;

        e.pixel_count = 25'(add_clamp_u({39'd0, e.pixel_count}, 64'd1, CNT_LIM));
        e.sum_x    = 37'(add_clamp_u({27'd0, e.sum_x}, xs, SUM_LIM));
        e.sum_y    = 37'(add_clamp_u({27'd0, e.sum_y}, ys, SUM_LIM));
        e.area_sum = add_clamp_u(e.area_sum, pa32, AREA_LIM);
        e.raw_unc  = add_clamp_u(e.raw_unc, {32'd0, cfg.raw_step} << 16, AREA_LIM);
        if (border)
            e.raw_unc = add_clamp_u(e.raw_unc, pa32, AREA_LIM);

        // limb-corrected area, else the pixel is clipped
        factor = 64'hFFFF_FFFF_FFFF_FFFF;
        if (r2 > d2)
        begin
            sigma  = r2 - d2;
            s      = floor_sqrt(sigma);
            factor = ({44'd0, cfg.radius} << 8) / s;
        end
        if (r2 > d2 && factor <= {48'd0, cfg.limb_limit})
        begin
            corr = ({32'd0, cfg.pixel_area} * factor) << 8;
            t    = ((dx + dy) << 8)
                 + 64'd2 * (({48'd0, cfg.radius_rel_var} * sigma) >> 16)
                 + (({48'd0, cfg.pixel_rel_var} * (r2 + sigma)) >> 16);
            num  = ({96'd0, cfg.pixel_area} * {64'd0, t}) << 24;
            dvs  = sigma * s;
            q128 = num / {64'd0, dvs};
            q    = (q128 > {64'd0, AREA_LIM}) ? AREA_LIM : q128[63:0];
            e.disk_area = add_clamp_u(e.disk_area, corr, AREA_LIM);
            e.disk_unc  = add_clamp_u(e.disk_unc, q, AREA_LIM);
            if (border)
                e.disk_unc = add_clamp_u(e.disk_unc, corr, AREA_LIM);
        end
        else
            e.clipped = 1'b1;
        region_tbl[k] = e;
    endtask

    // Queue the fourteen statistics of entry k
    task automatic queue_read_run(int k);
        rps_pkg::entry_t e;
        logic [63:0] vals [14];
        stat_rec_t   rec;
        e        = region_tbl[k];
        vals[0]  = {39'd0, e.pixel_count};
        vals[1]  = {39'd0, e.valid_count};
        vals[2]  = {27'd0, e.sum_x};
        vals[3]  = {27'd0, e.sum_y};
        vals[4]  = e.total;
        vals[5]  = e.wsum_x;
        vals[6]  = e.wsum_y;
        vals[7]  = {{32{e.imin[31]}}, e.imin};
        vals[8]  = {{32{e.imax[31]}}, e.imax};
        vals[9]  = e.area_sum;
        vals[10] = e.raw_unc;
        vals[11] = e.disk_area;
        vals[12] = e.disk_unc;
        vals[13] = {63'd0, e.clipped};
        for (int i = 0; i < 14; i++)
        begin
            rec.code  = rps_pkg::ST_PIXEL_COUNT + 4'(i);
            rec.value = vals[i];
            rec.last  = (rec.code == rps_pkg::ST_CLIPPED);
            expected_stats.insert(expected_stats.size(), rec);
        end
    endtask

    // Watch configuration and input transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg <= '0;
            for (int k = 0; k < rps_pkg::REGION_COUNT; k++)
                region_tbl[k] = '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    rps_pkg::REG_DISK_CENTER_X:   cfg.center_x       <= cfg_data[19:0];
                    rps_pkg::REG_DISK_CENTER_Y:   cfg.center_y       <= cfg_data[19:0];
                    rps_pkg::REG_DISK_RADIUS:     cfg.radius         <= cfg_data[19:0];
                    rps_pkg::REG_PIXEL_AREA:      cfg.pixel_area     <= cfg_data;
                    rps_pkg::REG_RAW_UNCERT_STEP: cfg.raw_step       <= cfg_data;
                    rps_pkg::REG_LIMB_LIMIT:      cfg.limb_limit     <= cfg_data[15:0];
                    rps_pkg::REG_RADIUS_REL_VAR:  cfg.radius_rel_var <= cfg_data[15:0];
                    rps_pkg::REG_PIXEL_REL_VAR:   cfg.pixel_rel_var  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (action == rps_pkg::ACT_ADD)
                    accumulate_pixel(int'(region_label), pixel_x, pixel_y, intensity,
                                     intensity_valid, at_border);
                else if (action == rps_pkg::ACT_READ)
                    queue_read_run(int'(region_label));
                else if (action == rps_pkg::ACT_CLEAR)
                    region_tbl[int'(region_label)] = '0;
            end
        end
    end

    // Compare each output transaction with the oldest expected statistic
    initial
    begin
        fail_count = 0;
        stats_seen = 0;
    end

    always @(posedge clk)
    begin
        stat_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            stats_seen++;
            if (expected_stats.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected statistic code %0d value %h last %0b",
                             stat_code, stat_value, last);
            end
            else
            begin
                want = expected_stats.pop_front();
                if (want.code != stat_code || want.value != stat_value || want.last != last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: statistic exp code %0d value %h last %0b, got %0d %h %0b",
                                 want.code, want.value, want.last,
                                 stat_code, stat_value, last);
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top for the region pixel statistics block: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] ACT_ADD    = rps_pkg::ACT_ADD;
    localparam logic [1:0] ACT_READ   = rps_pkg::ACT_READ;
    localparam logic [1:0] ACT_CLEAR  = rps_pkg::ACT_CLEAR;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE_CYCLES = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_ADD;
    logic [7:0]  region_label = '0;
    logic [11:0] pixel_x = '0;
    logic [11:0] pixel_y = '0;
    logic [31:0] intensity = '0;
    logic        intensity_valid = 1'b0;
    logic        at_border = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  stat_code;
    logic [63:0] stat_value;
    logic        last;

    int fail_count, pending, stats_seen;
    int items_sent = 0;
    int burst_left = 0;
    int cycles = 0;
    bit hold_req = 1'b0;

    region_pixel_statistics_top DUT (.*);

    region_pixel_statistics_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stall pattern, plus one long hold-off on request
    int stall_mode = 0;
    int hold_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req && hold_cnt < 400)
        begin
            hold_cnt++;
            out_stall <= 1'b1;
        end
        else
        begin
            if (cycles % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ((cycles % 8) < 3);
            endcase
        end
    end

    // Write the full register set; called at a rising edge while idle
    task automatic write_regs(logic [19:0] cx, logic [19:0] cy, logic [19:0] r,
                              logic [31:0] pa, logic [31:0] step, logic [15:0] limb,
                              logic [15:0] rrv, logic [15:0] prv);
        logic [31:0] vals [8];
        vals = '{{12'd0, cx}, {12'd0, cy}, {12'd0, r}, pa, step,
                 {16'd0, limb}, {16'd0, rrv}, {16'd0, prv}};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= rps_pkg::REG_DISK_CENTER_X + 3'(i);
            cfg_data     <= vals[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one transaction and wait until it is taken
    task automatic send(logic [1:0] act, logic [7:0] lbl, logic [11:0] x, logic [11:0] y,
                        logic [31:0] inten, logic iv, logic border);
        in_valid        <= 1'b1;
        action          <= act;
        region_label    <= lbl;
        pixel_x         <= x;
        pixel_y         <= y;
        intensity       <= inten;
        intensity_valid <= iv;
        at_border       <= border;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Sender pauses until every expected statistic has arrived and the block settles
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Burst and gap shaping before each random transaction
    task automatic pace;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Random transaction, mostly adds to a few labels, half the pixels around the disk
    task automatic random_item(int cx, int cy, int rad);
        int          sel, px, py;
        logic [1:0]  act;
        logic [7:0]  lbl;
        sel = $urandom_range(0, 99);
        act = (sel < 70) ? ACT_ADD : (sel < 88) ? ACT_READ : (sel < 96) ? ACT_CLEAR
                                                                      : ACT_UNUSED;
        lbl = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            px = cx + $urandom_range(0, 2 * rad) - rad;
            py = cy + $urandom_range(0, 2 * rad) - rad;
            px = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
            py = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
        end
        else
        begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
        end
        pace();
        send(act, lbl, 12'(px), 12'(py), $urandom, ($urandom_range(0, 99) < 85),
             1'($urandom));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typical disk: center 2048, radius 1000, limb limit 4.0
        write_regs(20'(2048 << 8), 20'(2048 << 8), 20'(1000 << 8), 32'h0001_0000,
                   32'h0000_0800, 16'h0400, 16'h0100, 16'h0080);

        // Directed: center pixel, intensity extremes, off disk, beyond limb, invalid
        send(ACT_ADD, 8'd1, 12'd2048, 12'd2048, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send(ACT_ADD, 8'd1, 12'd2048, 12'd2048, 32'h8000_0000, 1'b1, 1'b0);
        send(ACT_ADD, 8'd1, 12'd0, 12'd0, 32'h0000_0100, 1'b1, 1'b0);
        send(ACT_ADD, 8'd1, 12'd3038, 12'd2048, 32'h0000_0200, 1'b1, 1'b1);
        send(ACT_ADD, 8'd1, 12'd2100, 12'd2000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send(ACT_READ, 8'd1, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        // first valid intensity sets both min and max
        send(ACT_ADD, 8'd2, 12'd4095, 12'd4095, 32'h0000_0000, 1'b1, 1'b1);
        send(ACT_READ, 8'd2, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        // no valid intensity yet
        send(ACT_ADD, 8'd3, 12'd2500, 12'd1700, 32'h1234_5678, 1'b0, 1'b1);
        send(ACT_READ, 8'd3, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        send(ACT_CLEAR, 8'd1, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        send(ACT_READ, 8'd1, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        send(ACT_UNUSED, 8'd1, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send(ACT_ADD, 8'd255, 12'd2100, 12'd1900, 32'h7654_3210, 1'b1, 1'b1);
        send(ACT_ADD, 8'd255, 12'd1200, 12'd2048, 32'h8765_4321, 1'b1, 1'b0);
        send(ACT_READ, 8'd255, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        send(ACT_ADD, 8'd0, 12'd2047, 12'd2049, 32'hFFFF_FF00, 1'b1, 1'b1);
        send(ACT_READ, 8'd0, 12'hFFF, 12'hFFF, 32'h0, 1'b0, 1'b0);
        send(ACT_READ, 8'd200, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0);
        drain();

        // Random with the typical disk
        for (int i = 0; i < 55; i++)
            random_item(2048, 2048, 1100);
        drain();

        // All registers at their maximum
        write_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 40; i++)
            random_item(4095, 4095, 4095);
        drain();

        // All registers zero: every pixel clipped
        write_regs('0, '0, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 20; i++)
            random_item(0, 0, 100);
        drain();

        // Random settings; receiver holds off while reads pile up
        write_regs(20'($urandom_range(1024, 3072) << 8), 20'($urandom_range(1024, 3072) << 8),
                   20'($urandom_range(200, 1500) << 8), $urandom, $urandom,
                   16'($urandom_range(256, 65535)), 16'($urandom), 16'($urandom));
        hold_req <= 1'b1;
        for (int i = 0; i < 8; i++)
            send(ACT_READ, 8'($urandom_range(0, 7)), 12'($urandom), 12'($urandom),
                 $urandom, 1'b0, 1'b0);
        for (int i = 0; i < 38; i++)
            random_item(2048, 2048, 1500);
        drain();

        $display("Covered %0d input transactions over four register sets, %0d statistics checked",
                 items_sent, stats_seen);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rps_pkg.sv
rtl/core/rps_front.sv
rtl/core/rps_queue.sv
rtl/core/rps_back.sv
rtl/core/region_pixel_statistics_top.sv
tb/region_pixel_statistics_checker.sv
tb/tb.sv
